### rtl/crcfpr_pkg.sv
package crcfpr_pkg;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic REG_SEED_FIRST  = 1'b0;
   localparam logic REG_SEED_SECOND = 1'b1;

   localparam logic [7:0] SEED_FIRST_RESET  = 8'h5A;
   localparam logic [7:0] SEED_SECOND_RESET = 8'hA5;

   localparam logic [7:0]  SYNC_FIRST  = 8'h5A;
   localparam logic [7:0]  SYNC_SECOND = 8'hA5;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_TOP     = 16'h8000;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
   } seed_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [15:0] byte_index;
      logic        last;
      logic        frame_good;
   } rsp_type;

   typedef logic [7:0][15:0] seed_cols_type;

   function automatic logic [15:0] crc_shift(input logic [15:0] c);
      logic [15:0] t;
      t = {c[14:0], 1'b0};
      if ((c & CRC_TOP) != 16'h0000) begin
         t = t ^ CRC_POLY;
      end
      return t;
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = crc_shift(c);
      end
      return c;
   endfunction

   // elaboration only: advance a crc over a number of zero bytes
   function automatic logic [15:0] crc_zero_bytes(input logic [15:0] crc, input int count);
      logic [15:0] c;
      c = crc;
      for (int k = 0; k < count * 8; k++) begin
         c = crc_shift(c);
      end
      return c;
   endfunction

   // contribution of each seed bit once it is followed by zero bytes
   function automatic seed_cols_type seed_cols(input int zero_bytes);
      seed_cols_type r;
      for (int i = 0; i < 8; i++) begin
         r[i] = crc_zero_bytes(crc_byte(16'h0000, 8'(1 << i)), zero_bytes);
      end
      return r;
   endfunction

   localparam seed_cols_type SEED_FIRST_COLS  = seed_cols(3);
   localparam seed_cols_type SEED_SECOND_COLS = seed_cols(2);

   // crc of seed bytes followed by two zero bytes
   function automatic logic [15:0] seed_mix(input seed_type s);
      logic [15:0] r;
      r = 16'h0000;
      for (int i = 0; i < 8; i++) begin
         if (s.first[i]) begin
            r = r ^ SEED_FIRST_COLS[i];
         end
         if (s.second[i]) begin
            r = r ^ SEED_SECOND_COLS[i];
         end
      end
      return r;
   endfunction

endpackage

### rtl/crcfpr_csr.sv
module crcfpr_csr
   import crcfpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output seed_type              seeds
);

   seed_type seeds_ff;
   seed_type seeds_in;
   logic     wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      seeds_in = seeds_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_SEED_FIRST: begin
               seeds_in.first = csr_pwdata[7:0];
            end
            REG_SEED_SECOND: begin
               seeds_in.second = csr_pwdata[7:0];
            end
            default: begin
               seeds_in = seeds_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeds_ff.first  <= SEED_FIRST_RESET;
         seeds_ff.second <= SEED_SECOND_RESET;
      end else begin
         seeds_ff <= seeds_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_SEED_FIRST:  csr_prdata = {{(CSR_DATA_W-8){1'b0}}, seeds_ff.first};
         REG_SEED_SECOND: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, seeds_ff.second};
         default:         csr_prdata = '0;
      endcase
   end

   assign seeds = seeds_ff;

endmodule

### rtl/crcfpr_deframer.sv
module crcfpr_deframer
   import crcfpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  seed_type   seeds,
   output logic       emit,
   output rsp_type    rsp
);

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_SYNC2  = 3'd1;
   localparam logic [2:0] PH_LEN_LO = 3'd2;
   localparam logic [2:0] PH_LEN_HI = 3'd3;
   localparam logic [2:0] PH_CRC_LO = 3'd4;
   localparam logic [2:0] PH_CRC_HI = 3'd5;
   localparam logic [2:0] PH_DATA   = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [15:0] run_crc_ff, run_crc_in;
   logic [15:0] crc_next;
   logic [16:0] count_next;
   logic        fin;

   assign crc_next   = crc_byte(run_crc_ff, data_byte);
   assign count_next = {1'b0, count_ff} + 17'd1;
   assign fin        = count_next >= {1'b0, length_ff};

   always_comb begin
      phase_in   = phase_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      rx_crc_in  = rx_crc_ff;
      run_crc_in = run_crc_ff;
      unique case (phase_ff)
         PH_SYNC2: begin
            if (data_byte == SYNC_SECOND) begin
               phase_in = PH_LEN_LO;
            end
         end
         PH_LEN_LO: begin
            length_in  = {8'h00, data_byte};
            run_crc_in = crc_byte(16'h0000, data_byte);
            phase_in   = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in  = {data_byte, length_ff[7:0]};
            run_crc_in = crc_next;
            phase_in   = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            rx_crc_in = {8'h00, data_byte};
            phase_in  = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            rx_crc_in  = {data_byte, rx_crc_ff[7:0]};
            count_in   = 16'h0000;
            run_crc_in = seed_mix(seeds) ^ run_crc_ff;
            phase_in   = PH_DATA;
         end
         PH_DATA: begin
            run_crc_in = crc_next;
            count_in   = count_next[15:0];
            if (fin) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = (data_byte == SYNC_FIRST) ? PH_SYNC2 : PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         length_ff  <= 16'h0000;
         count_ff   <= 16'h0000;
         rx_crc_ff  <= 16'h0000;
         run_crc_ff <= 16'h0000;
      end else if (step) begin
         phase_ff   <= phase_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         rx_crc_ff  <= rx_crc_in;
         run_crc_ff <= run_crc_in;
      end
   end

   assign emit             = phase_ff == PH_DATA;
   assign rsp.payload_byte = data_byte;
   assign rsp.byte_index   = count_ff;
   assign rsp.last         = fin;
   assign rsp.frame_good   = fin && (crc_next == rx_crc_ff);

endmodule

### rtl/crc16_framed_packet_receiver_top.sv
// Framed packet receiver: takes one serial byte per item, hunts for the sync pair 0x5A 0xA5,
// reads a little-endian 16-bit length and CRC, then returns one item per payload byte with
// its index, a last flag and, on the last byte, whether the CRC-16 (poly 0x1021, init 0)
// over the two seed registers, the length bytes and the payload matches. Sync, length and
// CRC bytes produce no result. A byte can be taken every cycle; the input stalls only while
// a byte waits in the input register behind a result that the output is stalling. Each byte
// passes the input register and one byte-wide CRC update before landing in the result
// register, which raises rsp_valid. Seed registers are read when the high CRC byte is
// processed.
module crc16_framed_packet_receiver_top
   import crcfpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_payload_byte,
   output logic [15:0]           rsp_byte_index,
   output logic                  rsp_last,
   output logic                  rsp_frame_good,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   seed_type   seeds;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       advance;
   logic       emit;
   rsp_type    rsp_next;
   rsp_type    rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   crcfpr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .seeds       (seeds)
   );

   crcfpr_deframer u_deframer (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_data_ff),
      .seeds     (seeds),
      .emit      (emit),
      .rsp       (rsp_next)
   );

   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_valid || (in_valid_ff && !advance);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data_byte;
      end
      if (advance && emit) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_byte_index   = rsp_ff.byte_index;
   assign rsp_last         = rsp_ff.last;
   assign rsp_frame_good   = rsp_ff.frame_good;

`ifndef SYNTHESIS
   a_good_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_good |-> rsp_ff.last)
      else $error("frame_good set on a byte that is not last");

   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a full pipeline");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid_ff)
      else $error("valid state not cleared by reset");

   a_result_from_step: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(advance && emit))
      else $error("result appeared without a payload byte");
`endif

endmodule

### tb/sv/crc16_frame_checker.sv
`timescale 1ns / 1ps

module crc16_frame_checker
   import crcfpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [7:0]            rsp_payload_byte,
   input  logic [15:0]           rsp_byte_index,
   input  logic                  rsp_last,
   input  logic                  rsp_frame_good,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    failures,
   output int                    pending_results
);

   localparam logic [CSR_ADDR_W-1:0] ADDR_SEED_FIRST  = CSR_ADDR_W'(4 * REG_SEED_FIRST);
   localparam logic [CSR_ADDR_W-1:0] ADDR_SEED_SECOND = CSR_ADDR_W'(4 * REG_SEED_SECOND);

   typedef enum logic [2:0] {
      HUNT_SYNC1   = 3'd0,
      HUNT_SYNC2   = 3'd1,
      READ_LEN_LO  = 3'd2,
      READ_LEN_HI  = 3'd3,
      READ_CRC_LO  = 3'd4,
      READ_CRC_HI  = 3'd5,
      PASS_PAYLOAD = 3'd6
   } frame_phase_type;

   frame_phase_type phase;
   logic [15:0]     declared_length;
   logic [15:0]     payload_count;
   logic [15:0]     received_crc;
   logic [15:0]     running_crc;
   seed_type        seeds;
   rsp_type         expected_payload_q[$];

   // msb-first crc-16, one bit of the byte per step
   function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        feedback;
      c = crc;
      for (int k = 7; k >= 0; k--) begin
         feedback = c[15] ^ b[k];
         c = {c[14:0], 1'b0};
         if (feedback) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic logic deframe_byte(input logic [7:0] d, output rsp_type r);
      logic [16:0] next_count;
      logic        fin;
      logic        made;
      r = '0;
      made = 1'b0;
      case (phase)
         HUNT_SYNC2: begin
            if (d == SYNC_SECOND) begin
               phase = READ_LEN_LO;
            end
         end
         READ_LEN_LO: begin
            declared_length = {8'h00, d};
            phase = READ_LEN_HI;
         end
         READ_LEN_HI: begin
            declared_length[15:8] = d;
            phase = READ_CRC_LO;
         end
         READ_CRC_LO: begin
            received_crc = {8'h00, d};
            phase = READ_CRC_HI;
         end
         READ_CRC_HI: begin
            received_crc[15:8] = d;
            payload_count = 16'h0000;
            running_crc = crc16_fold(16'h0000, seeds.first);
            running_crc = crc16_fold(running_crc, seeds.second);
            running_crc = crc16_fold(running_crc, declared_length[7:0]);
            running_crc = crc16_fold(running_crc, declared_length[15:8]);
            phase = PASS_PAYLOAD;
         end
         PASS_PAYLOAD: begin
            running_crc = crc16_fold(running_crc, d);
            next_count = {1'b0, payload_count} + 17'd1;
            fin = (next_count >= {1'b0, declared_length});
            r.payload_byte = d;
            r.byte_index = payload_count;
            r.last = fin;
            r.frame_good = fin && (running_crc == received_crc);
            payload_count = next_count[15:0];
            if (fin) begin
               phase = HUNT_SYNC1;
            end
            made = 1'b1;
         end
         default: begin
            phase = (d == SYNC_FIRST) ? HUNT_SYNC2 : HUNT_SYNC1;
         end
      endcase
      return made;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h actual %0h", field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type made_rsp;
      rsp_type want;
      if (reset) begin
         phase = HUNT_SYNC1;
         declared_length = 16'h0000;
         payload_count = 16'h0000;
         received_crc = 16'h0000;
         running_crc = 16'h0000;
         seeds.first = SEED_FIRST_RESET;
         seeds.second = SEED_SECOND_RESET;
         expected_payload_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == ADDR_SEED_FIRST) begin
                  seeds.first = csr_pwdata[7:0];
               end else if (csr_paddr == ADDR_SEED_SECOND) begin
                  seeds.second = csr_pwdata[7:0];
               end
            end else if (csr_paddr == ADDR_SEED_FIRST) begin
               check_field("csr_prdata", CSR_DATA_W'(seeds.first), csr_prdata);
            end else if (csr_paddr == ADDR_SEED_SECOND) begin
               check_field("csr_prdata", CSR_DATA_W'(seeds.second), csr_prdata);
            end
         end
         if (req_valid && !req_stall) begin
            if (deframe_byte(req_data_byte, made_rsp)) begin
               expected_payload_q.push_back(made_rsp);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_payload_q.size() == 0) begin
               $error("unexpected item: payload_byte %0h byte_index %0h",
                      rsp_payload_byte, rsp_byte_index);
               failures++;
            end else begin
               want = expected_payload_q.pop_front();
               check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_payload_byte));
               check_field("byte_index", 32'(want.byte_index), 32'(rsp_byte_index));
               check_field("last", 32'(want.last), 32'(rsp_last));
               check_field("frame_good", 32'(want.frame_good), 32'(rsp_frame_good));
            end
         end
      end
      pending_results = expected_payload_q.size();
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
   import crcfpr_pkg::*;
;

   localparam int RANDOM_ITEMS     = 1350;
   localparam int SEED_PHASES      = 5;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int HOLD_FRAME_LEN   = 120;
   localparam int SETTLE_CYCLES    = 8;
   localparam int CYCLE_LIMIT      = 3000000;

   localparam logic [CSR_ADDR_W-1:0] ADDR_SEED_FIRST  = CSR_ADDR_W'(4 * REG_SEED_FIRST);
   localparam logic [CSR_ADDR_W-1:0] ADDR_SEED_SECOND = CSR_ADDR_W'(4 * REG_SEED_SECOND);

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_data_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [7:0]            rsp_payload_byte;
   logic [15:0]           rsp_byte_index;
   logic                  rsp_last;
   logic                  rsp_frame_good;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    failures;
   int                    pending_results;

   logic [7:0] seed_first;
   logic [7:0] seed_second;
   logic [7:0] frame_body[$];
   int         sent_items;
   int         cycle_count;
   bit         gaps_on;
   bit         hold_asked;
   bit         hold_served;

   crc16_framed_packet_receiver_top dut (.*);

   crc16_frame_checker frame_check (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int roll;
      int gap;
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      sent_items++;
      if (gaps_on) begin
         roll = $urandom_range(0, 99);
         gap = (roll < 65) ? 0 : (roll < 92) ? $urandom_range(1, 3) : $urandom_range(8, 50);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [7:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= addr;
      csr_pwdata <= CSR_DATA_W'(data);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_seeds(input logic [7:0] first, input logic [7:0] second);
      settle();
      csr_access(1'b1, ADDR_SEED_FIRST, first);
      csr_access(1'b1, ADDR_SEED_SECOND, second);
      csr_access(1'b0, ADDR_SEED_FIRST, 8'h00);
      csr_access(1'b0, ADDR_SEED_SECOND, 8'h00);
      seed_first = first;
      seed_second = second;
   endtask

   // payload comes from frame_body, which must hold max(len, 1) bytes
   task automatic send_frame(input logic [15:0] len, input int sync_junk, input bit bad_crc);
      logic [15:0] crc;
      logic [7:0]  junk;
      crc = crc_byte(16'h0000, seed_first);
      crc = crc_byte(crc, seed_second);
      crc = crc_byte(crc, len[7:0]);
      crc = crc_byte(crc, len[15:8]);
      foreach (frame_body[i]) begin
         crc = crc_byte(crc, frame_body[i]);
      end
      if (bad_crc) begin
         crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      end
      send_byte(SYNC_FIRST);
      repeat (sync_junk) begin
         do junk = 8'($urandom_range(0, 255)); while (junk == SYNC_SECOND);
         send_byte(junk);
      end
      send_byte(SYNC_SECOND);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
      foreach (frame_body[i]) begin
         send_byte(frame_body[i]);
      end
   endtask

   task automatic random_frame(input int len);
      logic [7:0] b;
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 6)) begin
            do b = 8'($urandom_range(0, 255)); while (b == SYNC_FIRST);
            send_byte(b);
         end
      end
      frame_body.delete();
      repeat ((len == 0) ? 1 : len) frame_body.push_back(8'($urandom_range(0, 255)));
      send_frame(16'(len), ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0,
                 $urandom_range(0, 3) == 0);
   endtask

   // receiver side
   initial begin
      int style;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_asked && !hold_served) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
         end else begin
            style = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200)) begin
               if (hold_asked && !hold_served) begin
                  break;
               end
               case (style)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 1) == 0);
                  default: begin
                     if ($urandom_range(0, 15) == 0) begin
                        rsp_stall <= 1'b1;
                        repeat ($urandom_range(5, 40)) @(posedge clock);
                     end
                     rsp_stall <= 1'b0;
                  end
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // sender side and verdict
   initial begin
      int target;
      int roll;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= 8'h00;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      sent_items = 0;
      gaps_on = 1'b0;
      hold_asked = 1'b0;
      hold_served = 1'b0;
      seed_first = SEED_FIRST_RESET;
      seed_second = SEED_SECOND_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero length still carries one byte
      frame_body = {8'h3C};
      send_frame(16'h0000, 0, 1'b0);
      // junk while waiting for second sync, bad crc, payload extremes
      frame_body = {8'h00, 8'hFF};
      send_frame(16'h0002, 1, 1'b1);
      // lone second sync ignored, repeated first sync keeps waiting
      send_byte(SYNC_SECOND);
      send_byte(SYNC_FIRST);
      frame_body = {8'hFF};
      send_frame(16'h0001, 0, 1'b0);

      for (int p = 0; p < SEED_PHASES; p++) begin
         case (p)
            0: ;
            1: set_seeds(8'h00, 8'h00);
            2: set_seeds(8'hFF, 8'hFF);
            default: set_seeds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         endcase
         target = sent_items + RANDOM_ITEMS / SEED_PHASES;
         if (p == 2) begin
            // receiver holds off while a long frame keeps coming
            hold_asked = 1'b1;
            gaps_on = 1'b0;
            random_frame(HOLD_FRAME_LEN);
         end
         while (sent_items < target) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            random_frame((roll < 70) ? $urandom_range(0, 8) :
                         (roll < 95) ? $urandom_range(9, 64) : $urandom_range(65, 300));
         end
      end

      settle();
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### files.f
rtl/crcfpr_pkg.sv
rtl/crcfpr_csr.sv
rtl/crcfpr_deframer.sv
rtl/crc16_framed_packet_receiver_top.sv
tb/sv/crc16_frame_checker.sv
tb/sv/tb_top.sv
